// ===== src/button_press_classifier_macros.svh =====
// Assertion macros for the button press classifier.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled in reset
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bpc_pkg.sv =====
// Shared types and constants for the button press classifier.
// No dependencies.
package bpc_pkg;

  localparam int TS_W   = 32;
  localparam int CFG_W  = 16;
  localparam int EV_W   = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

endpackage

// ===== src/bpc_if.sv =====
// Valid/ready channel interfaces for samples and press events.
// Depends on bpc_pkg.
interface bpc_in_if;
  import bpc_pkg::*;
  logic            valid;
  logic            ready;
  logic            raw_pressed;
  logic [TS_W-1:0] now_ms;
  modport source(output valid, raw_pressed, now_ms, input ready);
  modport sink(input valid, raw_pressed, now_ms, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic            valid;
  logic            ready;
  logic [EV_W-1:0] press_event;
  modport source(output valid, press_event, input ready);
  modport sink(input valid, press_event, output ready);
endinterface

// ===== src/bpc_cfg_regs.sv =====
// APB-style register file: debounce and long-press thresholds.
// Depends on bpc_pkg.
module bpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [bpc_pkg::DATA_W-1:0]    pwdata,
  output logic [bpc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output bpc_pkg::cfg_t                 cfg
);
  import bpc_pkg::*;

  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] long_press_r;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEBOUNCE:   debounce_r   <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS: long_press_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE:   prdata = DATA_W'(debounce_r);
      REG_LONG_PRESS: prdata = DATA_W'(long_press_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.debounce_ms   = debounce_r;
  assign cfg.long_press_ms = long_press_r;

endmodule

// ===== src/bpc_core.sv =====
// Debounce and press classification: state registers plus next-state logic.
// Depends on bpc_pkg.
module bpc_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       level,
  input  logic [bpc_pkg::TS_W-1:0]   now_ms,
  input  bpc_pkg::cfg_t              cfg,
  output logic [bpc_pkg::EV_W-1:0]   press_event
);
  import bpc_pkg::*;

  logic            raw_last_r,    raw_last_nxt;
  logic [TS_W-1:0] change_time_r, change_time_nxt;
  logic            held_r,        held_nxt;
  logic [TS_W-1:0] start_time_r,  start_time_nxt;
  logic            long_fired_r,  long_fired_nxt;
  logic            settled;
  logic            long_due;

  always_comb begin
    raw_last_nxt    = level;
    change_time_nxt = (level != raw_last_r) ? now_ms : change_time_r;
    held_nxt        = held_r;
    start_time_nxt  = start_time_r;
    long_fired_nxt  = long_fired_r;
    press_event     = EV_NONE;
    settled  = (now_ms - change_time_nxt) >= TS_W'(cfg.debounce_ms);
    long_due = (now_ms - start_time_r) >= TS_W'(cfg.long_press_ms);
    if (settled) begin
      priority if (level && !held_r) begin
        held_nxt       = 1'b1;
        start_time_nxt = now_ms;
        long_fired_nxt = 1'b0;
      end else if (level && held_r && !long_fired_r && long_due) begin
        long_fired_nxt = 1'b1;
        press_event    = EV_LONG;
      end else if (!level && held_r) begin
        held_nxt = 1'b0;
        if (!long_fired_r) press_event = EV_SHORT;
      end else begin
        press_event = EV_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_last_r    <= 1'b0;
      change_time_r <= '0;
      held_r        <= 1'b0;
      start_time_r  <= '0;
      long_fired_r  <= 1'b0;
    end else if (step) begin
      raw_last_r    <= raw_last_nxt;
      change_time_r <= change_time_nxt;
      held_r        <= held_nxt;
      start_time_r  <= start_time_nxt;
      long_fired_r  <= long_fired_nxt;
    end
  end

endmodule

// ===== src/button_press_classifier.sv =====
// Top level: input register, classifier core, result register, config regs.
// Depends on bpc_pkg, bpc_if, bpc_cfg_regs, bpc_core and the macros header.
//
//  channel  | ports            | moves
//  ---------+------------------+------------------------------------
//  in_ch    | valid/ready      | raw_pressed, now_ms per transaction
//  out_ch   | valid/ready      | press_event, one per input
//  cfg      | psel..pready APB | debounce_ms @0x0, long_press_ms @0x4
//
// Input and result are both registered; one transaction per cycle without stalls.
// The rate is set by the state update in bpc_core, done once per advanced item.
// Synchronous active-low reset clears both stages and the classifier state.
// A stalled output holds its result; the input register keeps accepting
// until it holds an item that cannot move on.
module button_press_classifier (
  input  logic                        clk,
  input  logic                        rst_n,
  bpc_in_if.sink                      in_ch,
  bpc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
  output logic [bpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bpc_pkg::*;
  `include "button_press_classifier_macros.svh"

  cfg_t            cfg;
  logic            s1_valid_r;
  logic            s1_level_r;
  logic [TS_W-1:0] s1_now_r;
  logic            out_valid_r;
  logic [EV_W-1:0] out_event_r;
  logic [EV_W-1:0] core_event;
  logic            s1_adv;
  logic            in_take;

  bpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  bpc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .level       (s1_level_r),
    .now_ms      (s1_now_r),
    .cfg         (cfg),
    .press_event (core_event)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_ch.raw_pressed;
      s1_now_r   <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event_r <= core_event;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.press_event = out_event_r;

  `BPC_ASSERT_NOW(a_no_bad_code, out_valid_r, out_event_r <= EV_LONG, "invalid press event code")
  `BPC_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r, "stage-1 item dropped")
  `BPC_ASSERT_NEXT(a_s1_to_out, s1_adv, out_valid_r, "advanced item missing at output")
  `BPC_ASSERT_NEXT(a_take_lands, in_take, s1_valid_r, "accepted transaction not registered")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for button_press_classifier: directed and random press sequences with
// per-sample event prediction. Depends on bpc_pkg, bpc_if and the RTL top level.
module tb_top;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 85;

  typedef enum int {RX_FREE, RX_HALF, RX_MOSTLY, RX_SLOW} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bpc_in_if  in_ch();
  bpc_out_if out_ch();

  button_press_classifier u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // debounce/long-press predictor state
  logic [CFG_W-1:0] deb_cfg      = DEBOUNCE_RST;
  logic [CFG_W-1:0] long_cfg     = LONG_PRESS_RST;
  logic             sw_raw_level = 1'b0;
  logic [TS_W-1:0]  sw_raw_ts    = '0;
  logic             sw_stable    = 1'b0;
  logic             sw_held      = 1'b0;
  logic [TS_W-1:0]  sw_press_ts  = '0;
  logic             sw_long_done = 1'b0;

  logic [EV_W-1:0]  pending_events[$];
  logic [EV_W-1:0]  want_event;
  int               mismatch_cnt = 0;
  int               cycle_cnt = 0;
  int               items_sent = 0;
  int               burst_left = 0;
  bit               sender_gaps = 1'b1;
  int               hold_left = 0;
  int               rx_left = 0;
  rx_mode_t         rx_mode = RX_FREE;
  logic [TS_W-1:0]  ts_now = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.raw_pressed = 1'b0;
    in_ch.now_ms   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
  end

  function automatic logic [EV_W-1:0] predict_event(input logic lvl, input logic [TS_W-1:0] ts);
    logic [EV_W-1:0] ev;
    logic [TS_W-1:0] elapsed;
    ev = EV_NONE;
    if (lvl != sw_raw_level) begin
      sw_raw_level = lvl;
      sw_raw_ts    = ts;
    end
    elapsed = ts - sw_raw_ts;
    if (elapsed >= TS_W'(deb_cfg)) begin
      sw_stable = sw_raw_level;
      elapsed   = ts - sw_press_ts;
      if (sw_stable && !sw_held) begin
        sw_held      = 1'b1;
        sw_press_ts  = ts;
        sw_long_done = 1'b0;
      end else if (sw_stable && sw_held && !sw_long_done && elapsed >= TS_W'(long_cfg)) begin
        sw_long_done = 1'b1;
        ev           = EV_LONG;
      end else if (!sw_stable && sw_held) begin
        sw_held = 1'b0;
        if (!sw_long_done) ev = EV_SHORT;
      end
    end
    return ev;
  endfunction

  function automatic logic [TS_W-1:0] around(input logic [TS_W-1:0] v);
    return v + TS_W'($urandom_range(0, 2)) - TS_W'(1);
  endfunction

  function automatic logic [TS_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return around(TS_W'(deb_cfg));
      2: return around(TS_W'(long_cfg));
      3: return TS_W'($urandom_range(0, 7));
      4: return TS_W'($urandom);
      default: return TS_W'($urandom_range(0, 2 * (int'(deb_cfg) + int'(long_cfg)) + 1));
    endcase
  endfunction

  task automatic send_sample(input logic lvl, input logic [TS_W-1:0] ts);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.raw_pressed = lvl;
    in_ch.now_ms      = ts;
    do @(posedge clk); while (!in_ch.ready);
    pending_events.push_back(predict_event(lvl, ts));
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [CFG_W-1:0] val);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_sel, 2'b00};
    pwdata  = {junk[DATA_W-1:CFG_W], val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_DEBOUNCE) deb_cfg = val;
    else long_cfg = val;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic cfg_read_check(input logic reg_sel, input logic [CFG_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {reg_sel, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(val)) begin
      $display("%0t ns: register %0d expected 0x%0h got 0x%0h", $time, reg_sel, val, prdata);
      mismatch_cnt++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_cfg_regs();
    cfg_read_check(REG_DEBOUNCE, deb_cfg);
    cfg_read_check(REG_LONG_PRESS, long_cfg);
  endtask

  // bounce, press, hold, bounce, release
  task automatic run_press();
    int n;
    int k;
    n = $urandom_range(0, 3);
    for (k = 0; k < n; k++) begin
      send_sample(k % 2 == 0, ts_now);
      ts_now += TS_W'($urandom_range(0, int'(deb_cfg)));
    end
    send_sample(1'b1, ts_now);
    ts_now += ($urandom_range(0, 4) == 0) ? pick_step() : around(TS_W'(deb_cfg));
    send_sample(1'b1, ts_now);
    n = $urandom_range(0, 4);
    for (k = 0; k < n; k++) begin
      ts_now += (k == 0 && $urandom_range(0, 1)) ? around(TS_W'(long_cfg)) : pick_step();
      send_sample(1'b1, ts_now);
    end
    n = $urandom_range(0, 3);
    for (k = 0; k < n; k++) begin
      ts_now += TS_W'($urandom_range(0, int'(deb_cfg)));
      send_sample(k % 2 != 0, ts_now);
    end
    send_sample(1'b0, ts_now);
    ts_now += ($urandom_range(0, 4) == 0) ? pick_step() : around(TS_W'(deb_cfg));
    send_sample(1'b0, ts_now);
    ts_now += TS_W'($urandom_range(0, 100));
    send_sample(1'b0, ts_now);
  endtask

  task automatic test_defaults_short_press();
    check_cfg_regs();
    send_sample(1'b0, 32'd10);
    send_sample(1'b1, 32'd100);
    send_sample(1'b0, 32'd120);
    send_sample(1'b1, 32'd130);
    send_sample(1'b1, 32'd179);
    send_sample(1'b1, 32'd180);
    send_sample(1'b0, 32'd600);
    send_sample(1'b0, 32'd650);
  endtask

  task automatic test_long_press();
    send_sample(1'b1, 32'd1000);
    send_sample(1'b1, 32'd1050);
    send_sample(1'b1, 32'd2049);
    send_sample(1'b1, 32'd2050);
    send_sample(1'b0, 32'd9100);
    send_sample(1'b0, 32'd9150);
  endtask

  // press across the 2^32 wrap, then a timestamp that goes backwards
  task automatic test_timestamp_wrap();
    send_sample(1'b1, 32'hFFFF_FFE0);
    send_sample(1'b1, 32'h0000_0012);
    send_sample(1'b1, 32'h0000_03FA);
    send_sample(1'b0, 32'h0000_0400);
    send_sample(1'b0, 32'h0000_0100);
  endtask

  task automatic test_threshold_extremes();
    wait_results_done();
    cfg_write(REG_DEBOUNCE, '0);
    cfg_write(REG_LONG_PRESS, '0);
    check_cfg_regs();
    send_sample(1'b1, 32'd5);
    send_sample(1'b1, 32'd5);
    send_sample(1'b0, 32'd5);
    send_sample(1'b1, 32'd7);
    send_sample(1'b0, 32'd7);
    wait_results_done();
    cfg_write(REG_DEBOUNCE, '1);
    cfg_write(REG_LONG_PRESS, '1);
    check_cfg_regs();
    send_sample(1'b1, 32'd0);
    send_sample(1'b1, 32'd65534);
    send_sample(1'b1, 32'd65535);
    send_sample(1'b1, 32'd131070);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'h0000_FFFE);
  endtask

  // receiver holds off while samples keep coming, then a full drain
  task automatic test_backpressure();
    int k;
    wait_results_done();
    cfg_write(REG_DEBOUNCE, 16'd3);
    cfg_write(REG_LONG_PRESS, 16'd20);
    hold_left = 400;
    sender_gaps = 1'b0;
    for (k = 0; k < 60; k++) begin
      ts_now += TS_W'($urandom_range(0, 8));
      send_sample(1'($urandom_range(0, 1)), ts_now);
    end
    sender_gaps = 1'b1;
    wait_results_done();
  endtask

  task automatic test_random_presses();
    int p;
    int start;
    logic [CFG_W-1:0] d;
    logic [CFG_W-1:0] l;
    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin d = '0; l = '0; end
        1: begin d = '1; l = '1; end
        2: begin d = '0; l = '1; end
        3: begin d = '1; l = '0; end
        4: begin d = DEBOUNCE_RST; l = LONG_PRESS_RST; end
        default: begin
          d = CFG_W'($urandom_range(1, 200));
          l = CFG_W'($urandom_range(0, 3000));
        end
      endcase
      wait_results_done();
      cfg_write(REG_DEBOUNCE, d);
      cfg_write(REG_LONG_PRESS, l);
      check_cfg_regs();
      ts_now = $urandom;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          run_press();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            ts_now += pick_step();
            send_sample(1'($urandom_range(0, 1)), ts_now);
          end
        end
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(5, 60);
        end
        rx_left--;
        case (rx_mode)
          RX_FREE:   out_ch.ready = 1'b1;
          RX_HALF:   out_ch.ready = 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ch.ready = ($urandom_range(0, 3) != 0);
          default:   out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t ns: press_event expected none got %0d", $time, out_ch.press_event);
        mismatch_cnt++;
      end else begin
        want_event = pending_events.pop_front();
        if (out_ch.press_event !== want_event) begin
          $display("%0t ns: press_event expected %0d got %0d", $time, want_event,
                   out_ch.press_event);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_defaults_short_press();
    test_long_press();
    test_timestamp_wrap();
    test_threshold_extremes();
    test_backpressure();
    test_random_presses();
    wait_results_done();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/bpc_pkg.sv
src/bpc_if.sv
src/bpc_cfg_regs.sv
src/bpc_core.sv
src/button_press_classifier.sv
dv/tb_top.sv
